// File: rtl/rdds_pkg.sv
// shared types and constants for the diagonal dominance statistics unit
// no dependencies
package rdds_pkg;

	localparam int unsigned MAX_ROWS_DEF = 65536;
	localparam int unsigned SUM_W        = 50;
	localparam int unsigned TOTAL_W      = 48;
	localparam int unsigned COUNT_W      = 17;
	localparam int unsigned RATIO_W      = 32;
	localparam int unsigned DVD_W        = SUM_W + 16;
	localparam int unsigned QUEUE_DEPTH  = 2;

	localparam logic [RATIO_W-1:0] RATIO_ALL = '1;
	localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// one finished row handed from the front to the back
	typedef struct packed {
		logic [15:0]      row_number;
		logic [SUM_W-1:0] diag;
		logic [SUM_W-1:0] offdiag;
		logic             mat_end;
	} row_rec_t;

endpackage

// File: rtl/rdds_if.sv
// channel interfaces: nonzero items, row results, configuration writes
// no dependencies
interface rdds_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value_real;
	logic signed [31:0] value_imag;
	logic [15:0]        column;
	logic [15:0]        block_size;
	logic               element_valid;
	logic               row_end;
	logic               matrix_end;

	modport source (output valid, value_real, value_imag, column, block_size,
		element_valid, row_end, matrix_end, input ready);
	modport sink (input valid, value_real, value_imag, column, block_size,
		element_valid, row_end, matrix_end, output ready);
endinterface

interface rdds_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] row_number;
	logic [31:0] row_ratio;
	logic        zero_diagonal;
	logic        stats_valid;
	logic [31:0] min_ratio;
	logic [31:0] max_ratio;
	logic [31:0] avg_ratio;
	logic [16:0] rows_counted;

	modport source (output valid, row_number, row_ratio, zero_diagonal, stats_valid,
		min_ratio, max_ratio, avg_ratio, rows_counted, input ready);
	modport sink (input valid, row_number, row_ratio, zero_diagonal, stats_valid,
		min_ratio, max_ratio, avg_ratio, rows_counted, output ready);
endinterface

interface rdds_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// File: rtl/csr_diagonal_dominance_stats_unit.sv
// Diagonal dominance statistics of a complex CSR matrix.
// Front: accept, square the real and imaginary parts, run the root digit loop, accumulate;
// it takes a new item only once the last is accumulated, paced by the one-digit-per-cycle square root.
// Back: the divider forms the ratio of each row with a nonzero diagonal, and at matrix end the average;
// rows queue two deep so the front keeps streaming while the back divides.
// arst_n zeroes row, block and sum state, block_mode, max, total and count; min resets to all ones.
module csr_diagonal_dominance_stats_unit import rdds_pkg::*; #(
	parameter int unsigned MAX_ROWS = MAX_ROWS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rdds_in_if.sink    items,
	rdds_out_if.source results,
	rdds_cfg_if.sink   cfg
);

	logic     block_mode_q;
	logic     q_push, q_pop, q_full, q_empty;
	row_rec_t q_rec, q_head;
	logic     back_idle;

	// writes only land while the front waits for an item, the queue is empty and the back is idle
	assign cfg.ready = back_idle && items.ready && q_empty;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_mode_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			block_mode_q <= cfg.data;
		end
	end

	rdds_front #(.MAX_ROWS(MAX_ROWS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.block_mode (block_mode_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_rec      (q_rec)
	);

	rdds_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_rec (q_rec),
		.pop      (q_pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (q_head)
	);

	rdds_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.results (results),
		.idle    (back_idle)
	);

endmodule

// File: rtl/rdds_front.sv
// front end: takes nonzeros, forms magnitudes, classifies and accumulates per row
// depends on rdds_pkg and rdds_in_if
module rdds_front import rdds_pkg::*; #(
	parameter int unsigned MAX_ROWS = MAX_ROWS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rdds_in_if.sink   items,
	input  logic      block_mode,
	input  logic      q_full,
	output logic      q_push,
	output row_rec_t  q_rec
);

	localparam int unsigned RW = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
	localparam int unsigned CW = ((RW > 16) ? RW : 16) + 2;
	localparam logic [RW-1:0] ROW_LAST = RW'(MAX_ROWS - 1);

	typedef enum logic [2:0] {F_IDLE, F_SQ_RE, F_SQ_IM, F_ROOT, F_ACC} fstate_t;

	fstate_t          state_q;
	logic [31:0]      abs_re_q, abs_im_q;
	logic [15:0]      column_q, bsz_q;
	logic             valid_q, row_done_q, mat_end_q;
	logic [63:0]      sq_q;
	logic [34:0]      rem_q;
	logic [31:0]      root_q;
	logic [4:0]       step_q;
	logic [RW-1:0]    current_row_q, block_first_q;
	logic [15:0]      block_off_q;
	logic [SUM_W-1:0] diag_q, offdiag_q;

	logic [31:0]      mul_a;
	logic [63:0]      mul_p;
	logic [35:0]      r_try;
	logic [35:0]      t_try;
	logic             take;
	logic [15:0]      bsz_in;
	logic [CW-1:0]    col_x, bfr_x;
	logic             is_diag;
	logic [SUM_W:0]   diag_add, off_add;
	logic [SUM_W-1:0] diag_new, off_new;
	logic [RW-1:0]    next_row;
	logic [16:0]      off_inc;

	assign items.ready = (state_q == F_IDLE);
	assign take        = items.valid && items.ready;
	assign bsz_in      = (items.block_size == 16'd0) ? 16'd1 : items.block_size;

	// one shared squarer
	assign mul_a = (state_q == F_SQ_RE) ? abs_re_q : abs_im_q;
	assign mul_p = 64'(mul_a) * 64'(mul_a);

	// one root digit per cycle
	assign r_try = {rem_q[33:0], sq_q[63:62]};
	assign t_try = {2'b00, root_q, 2'b01};

	// diagonal test and saturating accumulate
	assign col_x = CW'(column_q);
	assign bfr_x = CW'(block_first_q);
	always_comb begin
		if (block_mode) begin
			is_diag = (col_x >= bfr_x) && (col_x < bfr_x + CW'(bsz_q));
		end else begin
			is_diag = (col_x == CW'(current_row_q));
		end
	end

	assign diag_add = {1'b0, diag_q} + (SUM_W+1)'(root_q);
	assign off_add  = {1'b0, offdiag_q} + (SUM_W+1)'(root_q);
	always_comb begin
		diag_new = diag_q;
		off_new  = offdiag_q;
		if (valid_q) begin
			if (is_diag) begin
				diag_new = diag_add[SUM_W] ? SUM_MAX : diag_add[SUM_W-1:0];
			end else begin
				off_new = off_add[SUM_W] ? SUM_MAX : off_add[SUM_W-1:0];
			end
		end
	end

	assign next_row = (current_row_q == ROW_LAST) ? '0 : current_row_q + RW'(1);
	assign off_inc  = {1'b0, block_off_q} + 17'd1;

	assign q_push = (state_q == F_ACC) && row_done_q && !q_full;
	always_comb begin
		q_rec.row_number = 16'(current_row_q);
		q_rec.diag       = diag_new;
		q_rec.offdiag    = off_new;
		q_rec.mat_end    = mat_end_q;
	end

	// sequencer and row state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= F_IDLE;
			current_row_q <= '0;
			block_first_q <= '0;
			block_off_q   <= '0;
			diag_q        <= '0;
			offdiag_q     <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (take) begin
						state_q <= items.element_valid ? F_SQ_RE : F_ACC;
					end
				end
				F_SQ_RE: begin
					state_q <= F_SQ_IM;
				end
				F_SQ_IM: begin
					state_q <= F_ROOT;
				end
				F_ROOT: begin
					if (step_q == 5'd31) begin
						state_q <= F_ACC;
					end
				end
				F_ACC: begin
					if (!row_done_q) begin
						diag_q    <= diag_new;
						offdiag_q <= off_new;
						state_q   <= F_IDLE;
					end else if (!q_full) begin
						state_q   <= F_IDLE;
						diag_q    <= '0;
						offdiag_q <= '0;
						if (mat_end_q) begin
							current_row_q <= '0;
							block_first_q <= '0;
							block_off_q   <= '0;
						end else begin
							current_row_q <= next_row;
							if (next_row == '0 || off_inc >= {1'b0, bsz_q}) begin
								block_first_q <= next_row;
								block_off_q   <= '0;
							end else begin
								block_off_q <= off_inc[15:0];
							end
						end
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	// item and datapath registers
	always_ff @(posedge clk) begin
		if (take) begin
			abs_re_q   <= items.value_real[31] ? 32'(-items.value_real) : 32'(items.value_real);
			abs_im_q   <= items.value_imag[31] ? 32'(-items.value_imag) : 32'(items.value_imag);
			column_q   <= items.column;
			bsz_q      <= bsz_in;
			valid_q    <= items.element_valid;
			row_done_q <= items.row_end || items.matrix_end;
			mat_end_q  <= items.matrix_end;
			root_q     <= '0;
		end
		if (state_q == F_SQ_RE) begin
			sq_q <= mul_p;
		end
		if (state_q == F_SQ_IM) begin
			sq_q   <= sq_q + mul_p;
			rem_q  <= '0;
			root_q <= '0;
			step_q <= '0;
		end
		if (state_q == F_ROOT) begin
			sq_q   <= {sq_q[61:0], 2'b00};
			step_q <= step_q + 5'd1;
			if (r_try >= t_try) begin
				rem_q  <= 35'(r_try - t_try);
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= r_try[34:0];
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

endmodule

// File: rtl/rdds_fifo.sv
// short queue of finished rows between front and back
// depends on rdds_pkg
module rdds_fifo import rdds_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  row_rec_t push_rec,
	input  logic     pop,
	output logic     full,
	output logic     empty,
	output row_rec_t head
);

	localparam int unsigned PW = $clog2(QUEUE_DEPTH);

	row_rec_t        mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [PW:0]     cnt_q;

	assign full  = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_rec;
		end
	end

endmodule

// File: rtl/rdds_div.sv
// restoring divider, one quotient bit per cycle, quotient saturated to 32 bits
// depends on rdds_pkg
module rdds_div import rdds_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DVD_W-1:0]   dividend,
	input  logic [SUM_W-1:0]   divisor,
	output logic               done,
	output logic [RATIO_W-1:0] quotient
);

	localparam int unsigned CNT_W = $clog2(DVD_W + 1);

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DVD_W-1:0]   dvd_q;
	logic [SUM_W-1:0]   dsr_q;
	logic [SUM_W-1:0]   rem_q;
	logic [RATIO_W-1:0] quo_q;
	logic               sat_q;
	logic [SUM_W:0]     r_try;
	logic               fits;

	assign r_try    = {rem_q, dvd_q[DVD_W-1]};
	assign fits     = (r_try >= {1'b0, dsr_q});
	assign done     = busy_q && (cnt_q == '0);
	assign quotient = sat_q ? RATIO_ALL : quo_q;

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// shift and subtract
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
			sat_q <= 1'b0;
		end else if (busy_q && cnt_q != '0) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= fits ? SUM_W'(r_try - {1'b0, dsr_q}) : r_try[SUM_W-1:0];
			quo_q <= {quo_q[RATIO_W-2:0], fits};
			sat_q <= sat_q | quo_q[RATIO_W-1];
		end
	end

endmodule

// File: rtl/rdds_back.sv
// back end: row ratio, running statistics and the result register
// depends on rdds_pkg, rdds_div and rdds_out_if
module rdds_back import rdds_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  row_rec_t  q_head,
	output logic      q_pop,
	rdds_out_if.source results,
	output logic      idle
);

	typedef enum logic [2:0] {B_IDLE, B_DIV, B_STAT, B_AVG_GO, B_AVG, B_OUT} bstate_t;

	bstate_t            state_q;
	row_rec_t           rec_q;
	logic [RATIO_W-1:0] ratio_q;
	logic               zero_q;
	logic [RATIO_W-1:0] min_q, max_q, avg_q;
	logic [TOTAL_W-1:0] total_q;
	logic [COUNT_W-1:0] count_q;
	logic               out_valid_q;

	logic               div_start, div_done;
	logic [DVD_W-1:0]   div_dvd;
	logic [SUM_W-1:0]   div_dsr;
	logic [RATIO_W-1:0] div_quo;
	logic [TOTAL_W:0]   total_add;
	logic               out_free;
	logic               out_load;

	assign q_pop    = (state_q == B_IDLE) && !q_empty;
	assign out_free = !out_valid_q || results.ready;
	assign out_load = (state_q == B_OUT) && out_free;
	assign idle     = (state_q == B_IDLE) && q_empty && !out_valid_q;

	// divider operands: ratio on a new row, average once the statistics settle
	always_comb begin
		div_start = 1'b0;
		div_dvd   = {q_head.offdiag, 16'd0};
		div_dsr   = q_head.diag;
		if (state_q == B_IDLE) begin
			div_start = !q_empty && (q_head.diag != '0);
		end else if (state_q == B_AVG_GO) begin
			div_start = (count_q != '0);
			div_dvd   = DVD_W'(total_q);
			div_dsr   = SUM_W'(count_q);
		end
	end

	rdds_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign total_add = {1'b0, total_q} + (TOTAL_W+1)'(ratio_q);

	// sequencer, statistics and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			min_q       <= RATIO_ALL;
			max_q       <= '0;
			total_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						rec_q   <= q_head;
						zero_q  <= (q_head.diag == '0);
						ratio_q <= RATIO_ALL;
						state_q <= (q_head.diag == '0) ? B_STAT : B_DIV;
					end
				end
				B_DIV: begin
					if (div_done) begin
						ratio_q <= div_quo;
						state_q <= B_STAT;
					end
				end
				B_STAT: begin
					avg_q <= '0;
					if (!zero_q) begin
						if (ratio_q < min_q) begin
							min_q <= ratio_q;
						end
						if (ratio_q > max_q) begin
							max_q <= ratio_q;
						end
						total_q <= total_add[TOTAL_W] ? TOTAL_MAX : total_add[TOTAL_W-1:0];
						if (count_q != COUNT_MAX) begin
							count_q <= count_q + COUNT_W'(1);
						end
					end
					state_q <= rec_q.mat_end ? B_AVG_GO : B_OUT;
				end
				// average division starts from the settled total and count
				B_AVG_GO: begin
					state_q <= (count_q != '0) ? B_AVG : B_OUT;
				end
				B_AVG: begin
					if (div_done) begin
						avg_q   <= div_quo;
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (out_load) begin
						results.row_number    <= rec_q.row_number;
						results.row_ratio     <= ratio_q;
						results.zero_diagonal <= zero_q;
						results.stats_valid   <= rec_q.mat_end;
						results.min_ratio     <= rec_q.mat_end ? min_q : '0;
						results.max_ratio     <= rec_q.mat_end ? max_q : '0;
						results.avg_ratio     <= rec_q.mat_end ? avg_q : '0;
						results.rows_counted  <= rec_q.mat_end ? count_q : '0;
						if (rec_q.mat_end) begin
							min_q   <= RATIO_ALL;
							max_q   <= '0;
							total_q <= '0;
							count_q <= '0;
						end
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign results.valid = out_valid_q;

endmodule
